### hdl/burnt_pancake_sorter_core_assert.svh
// Assertion macros for the burnt pancake sorter core.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef BURNT_PANCAKE_SORTER_CORE_ASSERT_SVH
`define BURNT_PANCAKE_SORTER_CORE_ASSERT_SVH

// same-cycle implication
`define BPSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BPSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/bpsc_pkg.sv
// Shared types and constants for the burnt pancake sorter core.
// No dependencies.
package bpsc_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int VW_DEF    = 16;
  localparam int VW_MAX    = 32;
  localparam int DEPTH_MAX = 64;
  localparam int IDX_MAXW  = 6;
  localparam int CNT_MAXW  = 7;
  localparam int MOVE_W    = 9;
  localparam logic [MOVE_W-1:0] MOVE_MAX = 9'd511;
  localparam int Q_DEPTH   = 2;
  localparam int OUT_W     = 16;

  // item handed from intake to engine
  typedef struct packed {
    logic [VW_MAX-1:0]   value;
    logic [CNT_MAXW-1:0] height;
    logic [IDX_MAXW-1:0] idx;
    logic                keep;
    logic                last;
    logic                ovf;
  } cmd_t;

  // result item handed from engine to output queue
  typedef struct packed {
    logic [VW_MAX-1:0] value;
    logic [MOVE_W-1:0] moves;
    logic              ovf;
    logic              last;
  } res_t;

  typedef struct packed {
    logic busy;
    logic emitting;
  } stat_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CONT, S_SCAN_RD, S_SCAN_CMP, S_DECIDE,
    S_F_RDLO, S_F_RDHI, S_F_WRLO, S_F_WRHI,
    S_T_RD, S_T_CHK, S_FIX_RD, S_FIX_CHK, S_E_RD, S_E_PUSH
  } state_e;

  typedef enum logic [3:0] {
    C_HCHK, C_NEXTH, C_TURNTOP, C_FLIPH, C_FIXCHK,
    C_FIXTURN, C_FIXBACK, C_FIXNEXT, C_EMIT
  } cont_e;

  typedef enum logic [1:0] {
    T_POS, T_NEG, T_ANY
  } tmode_e;

  function automatic logic [MOVE_W-1:0] sat_inc(input logic [MOVE_W-1:0] m);
    sat_inc = (m == MOVE_MAX) ? m : m + MOVE_W'(1);
  endfunction

endpackage

### hdl/bpsc_queue.sv
// Small FIFO used between intake and engine, and in front of the result port.
// Depends on nothing.
module bpsc_queue #(
  parameter int W = 8,
  parameter int D = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);
  localparam int PW = (D > 1) ? $clog2(D) : 1;
  localparam int CW = $clog2(D + 1);

  logic [W-1:0]  ent_q [D];
  logic [PW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(D));
  assign empty_o = (cnt_q == '0);
  assign data_o  = ent_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= (wp_q == PW'(D - 1)) ? '0 : wp_q + PW'(1);
      if (do_pop)  rp_q <= (rp_q == PW'(D - 1)) ? '0 : rp_q + PW'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) ent_q[wp_q] <= data_i;
  end

endmodule

### hdl/bpsc_intake.sv
// Front end: counts the stack as it loads, flags dropped items, builds commands.
// Depends on bpsc_pkg.
module bpsc_intake #(
  parameter int DEPTH = bpsc_pkg::DEPTH_DEF,
  parameter int VW    = bpsc_pkg::VW_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      take_i,
  input  logic [bpsc_pkg::OUT_W-1:0] value_i,
  input  logic                      last_i,
  output bpsc_pkg::cmd_t            cmd_o
);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  logic          keep;
  logic [VW-1:0] val_w;

  assign keep  = (cnt_q < CW'(DEPTH));
  assign val_w = VW'($unsigned(value_i));

  always_comb begin
    cmd_o        = '0;
    cmd_o.value  = bpsc_pkg::VW_MAX'(val_w);
    cmd_o.idx    = bpsc_pkg::IDX_MAXW'(cnt_q[IW-1:0]);
    cmd_o.height = keep ? bpsc_pkg::CNT_MAXW'(cnt_q + CW'(1)) : bpsc_pkg::CNT_MAXW'(cnt_q);
    cmd_o.keep   = keep;
    cmd_o.last   = last_i;
    cmd_o.ovf    = ovf_q || !keep;
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (take_i) begin
      if (last_i) begin
        cnt_d = '0;
        ovf_d = 1'b0;
      end else if (keep) begin
        cnt_d = cnt_q + CW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

### hdl/bpsc_engine.sv
// Back end: holds the stack memory and sequences the flips, turns and output.
// Depends on bpsc_pkg.
module bpsc_engine #(
  parameter int DEPTH = bpsc_pkg::DEPTH_DEF,
  parameter int VW    = bpsc_pkg::VW_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bpsc_pkg::cmd_t   cmd_i,
  input  logic             cmd_empty_i,
  output logic             cmd_pop_o,
  input  logic             res_full_i,
  output logic             res_push_o,
  output bpsc_pkg::res_t   res_o,
  output bpsc_pkg::stat_t  stat_o
);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int MW = bpsc_pkg::MOVE_W;

  logic [VW-1:0] mem [DEPTH];
  logic [VW-1:0] rdata_q;

  bpsc_pkg::state_e state_q, state_d;
  bpsc_pkg::cont_e  cont_q, cont_d;
  bpsc_pkg::tmode_e tmode_q, tmode_d;

  logic [CW-1:0] n_q, n_d, h_q, h_d, sc_q, sc_d;
  logic [IW-1:0] i_q, i_d, best_q, best_d, lo_q, lo_d, hi_q, hi_d, k_q, k_d;
  logic [VW-1:0] bmag_q, bmag_d, tmp_q, tmp_d;
  logic [MW-1:0] moves_q, moves_d;
  logic          ovf_q, ovf_d;

  logic          wr_en;
  logic [IW-1:0] wr_addr, rd_addr;
  logic [VW-1:0] wr_data;

  logic [VW-1:0] neg_r, mag_r;
  logic          r_neg, r_pos, t_cond;

  assign neg_r = VW'(0) - rdata_q;
  assign r_neg = rdata_q[VW-1];
  assign r_pos = !rdata_q[VW-1] && (rdata_q != '0);
  assign mag_r = r_neg ? neg_r : rdata_q;

  always_comb begin
    unique case (tmode_q)
      bpsc_pkg::T_POS: t_cond = r_pos;
      bpsc_pkg::T_NEG: t_cond = r_neg;
      bpsc_pkg::T_ANY: t_cond = 1'b1;
      default:         t_cond = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;  cont_d = cont_q;  tmode_d = tmode_q;
    n_d = n_q;  h_d = h_q;  sc_d = sc_q;  i_d = i_q;  best_d = best_q;
    lo_d = lo_q;  hi_d = hi_q;  k_d = k_q;  bmag_d = bmag_q;  tmp_d = tmp_q;
    moves_d = moves_q;  ovf_d = ovf_q;
    wr_en = 1'b0;  wr_addr = '0;  wr_data = '0;  rd_addr = '0;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o       = '0;
    res_o.value = bpsc_pkg::VW_MAX'(rdata_q);
    res_o.moves = moves_q;
    res_o.ovf   = ovf_q;
    res_o.last  = (k_q == IW'(n_q - CW'(1)));

    unique case (state_q)
      bpsc_pkg::S_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.keep) begin
            wr_en   = 1'b1;
            wr_addr = cmd_i.idx[IW-1:0];
            wr_data = cmd_i.value[VW-1:0];
          end
          if (cmd_i.last) begin
            n_d     = CW'(cmd_i.height);
            h_d     = CW'(cmd_i.height);
            moves_d = '0;
            ovf_d   = cmd_i.ovf;
            cont_d  = bpsc_pkg::C_HCHK;
            state_d = bpsc_pkg::S_CONT;
          end
        end
      end
      bpsc_pkg::S_CONT: begin
        unique case (cont_q)
          bpsc_pkg::C_HCHK: begin
            if (h_q > CW'(1)) begin
              sc_d = '0;  best_d = '0;  bmag_d = '0;
              state_d = bpsc_pkg::S_SCAN_RD;
            end else begin
              i_d    = IW'(n_q - CW'(1));
              cont_d = bpsc_pkg::C_FIXCHK;
            end
          end
          bpsc_pkg::C_NEXTH: begin
            h_d    = h_q - CW'(1);
            cont_d = bpsc_pkg::C_HCHK;
          end
          bpsc_pkg::C_TURNTOP: begin
            tmode_d = bpsc_pkg::T_POS;
            cont_d  = bpsc_pkg::C_FLIPH;
            state_d = bpsc_pkg::S_T_RD;
          end
          bpsc_pkg::C_FLIPH: begin
            lo_d = '0;  hi_d = IW'(h_q - CW'(1));
            moves_d = bpsc_pkg::sat_inc(moves_q);
            cont_d  = bpsc_pkg::C_NEXTH;
            state_d = bpsc_pkg::S_F_RDLO;
          end
          bpsc_pkg::C_FIXCHK: begin
            if (i_q == '0) begin
              tmode_d = bpsc_pkg::T_NEG;
              cont_d  = bpsc_pkg::C_EMIT;
              state_d = bpsc_pkg::S_T_RD;
            end else begin
              state_d = bpsc_pkg::S_FIX_RD;
            end
          end
          bpsc_pkg::C_FIXTURN: begin
            tmode_d = bpsc_pkg::T_ANY;
            cont_d  = bpsc_pkg::C_FIXBACK;
            state_d = bpsc_pkg::S_T_RD;
          end
          bpsc_pkg::C_FIXBACK: begin
            lo_d = '0;  hi_d = i_q;
            moves_d = bpsc_pkg::sat_inc(moves_q);
            cont_d  = bpsc_pkg::C_FIXNEXT;
            state_d = bpsc_pkg::S_F_RDLO;
          end
          bpsc_pkg::C_FIXNEXT: begin
            i_d    = i_q - IW'(1);
            cont_d = bpsc_pkg::C_FIXCHK;
          end
          bpsc_pkg::C_EMIT: begin
            k_d     = '0;
            state_d = bpsc_pkg::S_E_RD;
          end
          default: state_d = bpsc_pkg::S_IDLE;
        endcase
      end
      bpsc_pkg::S_SCAN_RD: begin
        rd_addr = sc_q[IW-1:0];
        state_d = bpsc_pkg::S_SCAN_CMP;
      end
      bpsc_pkg::S_SCAN_CMP: begin
        // ties go to the deeper index
        if (bmag_q <= mag_r) begin
          best_d = sc_q[IW-1:0];
          bmag_d = mag_r;
        end
        sc_d    = sc_q + CW'(1);
        state_d = (sc_q + CW'(1) == h_q) ? bpsc_pkg::S_DECIDE : bpsc_pkg::S_SCAN_RD;
      end
      bpsc_pkg::S_DECIDE: begin
        if (best_q != IW'(h_q - CW'(1))) begin
          cont_d = bpsc_pkg::C_TURNTOP;
          if (best_q != '0) begin
            lo_d = '0;  hi_d = best_q;
            moves_d = bpsc_pkg::sat_inc(moves_q);
            state_d = bpsc_pkg::S_F_RDLO;
          end else begin
            state_d = bpsc_pkg::S_CONT;
          end
        end else begin
          cont_d  = bpsc_pkg::C_NEXTH;
          state_d = bpsc_pkg::S_CONT;
        end
      end
      bpsc_pkg::S_F_RDLO: begin
        rd_addr = lo_q;
        state_d = (lo_q > hi_q) ? bpsc_pkg::S_CONT : bpsc_pkg::S_F_RDHI;
      end
      bpsc_pkg::S_F_RDHI: begin
        tmp_d = rdata_q;
        if (lo_q == hi_q) begin
          // middle pancake of an odd prefix: negate in place
          wr_en = 1'b1;  wr_addr = lo_q;  wr_data = neg_r;
          state_d = bpsc_pkg::S_CONT;
        end else begin
          rd_addr = hi_q;
          state_d = bpsc_pkg::S_F_WRLO;
        end
      end
      bpsc_pkg::S_F_WRLO: begin
        wr_en = 1'b1;  wr_addr = lo_q;  wr_data = neg_r;
        state_d = bpsc_pkg::S_F_WRHI;
      end
      bpsc_pkg::S_F_WRHI: begin
        wr_en = 1'b1;  wr_addr = hi_q;  wr_data = VW'(0) - tmp_q;
        lo_d = lo_q + IW'(1);
        hi_d = hi_q - IW'(1);
        state_d = bpsc_pkg::S_F_RDLO;
      end
      bpsc_pkg::S_T_RD: begin
        rd_addr = '0;
        state_d = bpsc_pkg::S_T_CHK;
      end
      bpsc_pkg::S_T_CHK: begin
        if (t_cond) begin
          wr_en = 1'b1;  wr_addr = '0;  wr_data = neg_r;
          moves_d = bpsc_pkg::sat_inc(moves_q);
        end
        state_d = bpsc_pkg::S_CONT;
      end
      bpsc_pkg::S_FIX_RD: begin
        rd_addr = i_q;
        state_d = bpsc_pkg::S_FIX_CHK;
      end
      bpsc_pkg::S_FIX_CHK: begin
        if (r_neg) begin
          lo_d = '0;  hi_d = i_q;
          moves_d = bpsc_pkg::sat_inc(moves_q);
          cont_d  = bpsc_pkg::C_FIXTURN;
          state_d = bpsc_pkg::S_F_RDLO;
        end else begin
          cont_d  = bpsc_pkg::C_FIXNEXT;
          state_d = bpsc_pkg::S_CONT;
        end
      end
      bpsc_pkg::S_E_RD: begin
        rd_addr = k_q;
        state_d = bpsc_pkg::S_E_PUSH;
      end
      bpsc_pkg::S_E_PUSH: begin
        rd_addr = k_q;
        if (!res_full_i) begin
          res_push_o = 1'b1;
          if (res_o.last) begin
            state_d = bpsc_pkg::S_IDLE;
          end else begin
            k_d     = k_q + IW'(1);
            state_d = bpsc_pkg::S_E_RD;
          end
        end
      end
      default: state_d = bpsc_pkg::S_IDLE;
    endcase
  end

  assign stat_o.busy     = (state_q != bpsc_pkg::S_IDLE);
  assign stat_o.emitting = (state_q == bpsc_pkg::S_E_RD) || (state_q == bpsc_pkg::S_E_PUSH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpsc_pkg::S_IDLE;
      cont_q  <= bpsc_pkg::C_HCHK;
      tmode_q <= bpsc_pkg::T_POS;
      n_q     <= '0;
      h_q     <= '0;
      sc_q    <= '0;
      i_q     <= '0;
      best_q  <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      k_q     <= '0;
      moves_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cont_q  <= cont_d;
      tmode_q <= tmode_d;
      n_q     <= n_d;
      h_q     <= h_d;
      sc_q    <= sc_d;
      i_q     <= i_d;
      best_q  <= best_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      k_q     <= k_d;
      moves_q <= moves_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bmag_q <= bmag_d;
    tmp_q  <= tmp_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rdata_q <= mem[rd_addr];
  end

endmodule

### hdl/burnt_pancake_sorter_core.sv
// Top level of the burnt pancake sorter: intake, command queue, engine, result queue.
// Depends on bpsc_pkg, bpsc_intake, bpsc_queue, bpsc_engine and the assert header.
//
//   channel  | handshake          | payload
//   ---------+--------------------+---------------------------------------------
//   items in | push / full        | pancake_value_i, is_last_i
//   results  | pop / empty        | sorted_value_o, move_count_o, was_truncated_o,
//            |                    | last_out_o
//
// Loading takes one item per cycle until the two-entry command queue backs up.
// On the last item the engine sorts in one stack memory with a read and a write
// port (one read and one write a cycle): it scans for the largest magnitude, flips
// a prefix and turns the top pancake as needed, then emits each result in turn.
// Intake keeps filling the command queue during a sort; full rises when it is full.
// Reset (rst_ni low, asynchronous) clears all control; the stack memory is not cleared.
module burnt_pancake_sorter_core #(
  parameter int DEPTH = bpsc_pkg::DEPTH_DEF,
  parameter int VW    = bpsc_pkg::VW_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic signed [15:0] pancake_value_i,
  input  logic        is_last_i,
  input  logic        pop,
  output logic        empty,
  output logic signed [15:0] sorted_value_o,
  output logic [8:0]  move_count_o,
  output logic        was_truncated_o,
  output logic        last_out_o
);
  `include "burnt_pancake_sorter_core_assert.svh"

  bpsc_pkg::cmd_t  cmd_in, cmd_out;
  bpsc_pkg::res_t  res_in, res_out;
  bpsc_pkg::stat_t stat;
  logic            take;
  logic            cmd_empty, cmd_pop;
  logic            res_full, res_push;

  // an item is taken whenever the command queue has room
  assign take = push && !full;

  bpsc_intake #(.DEPTH(DEPTH), .VW(VW)) u_intake (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .value_i (pancake_value_i),
    .last_i  (is_last_i),
    .cmd_o   (cmd_in)
  );

  bpsc_queue #(.W($bits(bpsc_pkg::cmd_t)), .D(bpsc_pkg::Q_DEPTH)) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  bpsc_engine #(.DEPTH(DEPTH), .VW(VW)) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .stat_o      (stat)
  );

  // two-entry output queue: lets the engine finish a result while one waits
  bpsc_queue #(.W($bits(bpsc_pkg::res_t)), .D(bpsc_pkg::Q_DEPTH)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  // stored bits come out zero-extended from VW to the port width
  assign sorted_value_o  = $signed(16'(res_out.value[VW-1:0]));
  assign move_count_o    = res_out.moves;
  assign was_truncated_o = res_out.ovf;
  assign last_out_o      = res_out.last;

  `BPSC_ASSERT_NOW(a_cmd_pop_ok, cmd_pop, !cmd_empty && !stat.busy, "command popped while busy or empty")
  `BPSC_ASSERT_NOW(a_res_push_ok, res_push, !res_full && stat.emitting, "result pushed out of turn")
  `BPSC_ASSERT_NEXT(a_last_ends, res_push && res_in.last, !stat.busy, "engine busy after last result")

endmodule

### tb/burnt_pancake_sorter_core_tb.sv
// Self-checking testbench for burnt_pancake_sorter_core: loads directed and
// random stacks, predicts the sorted stack and move count, and checks every
// result item. Depends on the core RTL and bpsc_pkg.
module burnt_pancake_sorter_core_tb;

  localparam int DEPTH = 16;

  typedef struct {
    logic signed [15:0] value;
    logic               last;
  } pancake_item_t;

  typedef struct {
    logic signed [15:0] value;
    logic [8:0]         moves;
    logic               trunc;
    logic               last;
  } sorted_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic signed [15:0] pancake_value_i = '0;
  logic is_last_i = 1'b0;
  logic pop = 1'b0;
  logic empty;
  logic signed [15:0] sorted_value_o;
  logic [8:0] move_count_o;
  logic was_truncated_o;
  logic last_out_o;

  burnt_pancake_sorter_core dut (
    .clk_i, .rst_ni, .push, .full, .pancake_value_i, .is_last_i,
    .pop, .empty, .sorted_value_o, .move_count_o, .was_truncated_o, .last_out_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state: the stack being loaded
  logic signed [15:0] stack_q [DEPTH];
  int unsigned        stack_cnt;
  int unsigned        move_tally;
  logic               dropped_seen;

  pancake_item_t pending_items[$];
  sorted_item_t  expected_sorted[$];
  int unsigned   fail_cnt;
  int unsigned   result_cnt;
  int unsigned   stack_runs;
  int unsigned   send_idle_pct;
  int unsigned   recv_idle_pct;

  // magnitude; most negative value maps to 2^15
  function automatic int unsigned size_of(logic signed [15:0] v);
    return (v < 0) ? int'(-32'(v)) : int'(v);
  endfunction

  function automatic void bump_moves();
    if (move_tally < 511) move_tally++;
  endfunction

  // reverse positions 0..n and negate each (16-bit wrap)
  function automatic void flip_prefix(int unsigned n);
    logic signed [15:0] t;
    for (int unsigned lo = 0, hi = n; lo < hi; lo++, hi--) begin
      t = stack_q[lo];
      stack_q[lo] = stack_q[hi];
      stack_q[hi] = t;
    end
    for (int unsigned i = 0; i <= n; i++) stack_q[i] = -stack_q[i];
  endfunction

  function automatic void sort_loaded(int unsigned height);
    int unsigned best;
    move_tally = 0;
    for (int unsigned h = height; h > 1; h--) begin
      best = 0;
      for (int unsigned i = 0; i < h; i++)
        if (size_of(stack_q[best]) <= size_of(stack_q[i])) best = i;
      if (best != h - 1) begin
        if (best != 0) begin
          flip_prefix(best);
          bump_moves();
        end
        if (stack_q[0] > 0) begin
          stack_q[0] = -stack_q[0];
          bump_moves();
        end
        flip_prefix(h - 1);
        bump_moves();
      end
    end
    for (int unsigned i = height - 1; i > 0; i--) begin
      if (stack_q[i] < 0) begin
        flip_prefix(i);
        bump_moves();
        stack_q[0] = -stack_q[0];
        bump_moves();
        flip_prefix(i);
        bump_moves();
      end
    end
    if (stack_q[0] < 0) begin
      stack_q[0] = -stack_q[0];
      bump_moves();
    end
  endfunction

  // called for each accepted item
  function automatic void load_pancake(pancake_item_t it);
    sorted_item_t r;
    if (stack_cnt < DEPTH) begin
      stack_q[stack_cnt] = it.value;
      stack_cnt++;
    end else begin
      dropped_seen = 1'b1;
    end
    if (!it.last) return;
    sort_loaded(stack_cnt);
    for (int unsigned k = 0; k < stack_cnt; k++) begin
      r.value = stack_q[k];
      r.moves = 9'(move_tally);
      r.trunc = dropped_seen;
      r.last  = (k + 1 == stack_cnt);
      expected_sorted.push_back(r);
    end
    stack_runs++;
    stack_cnt = 0;
    move_tally = 0;
    dropped_seen = 1'b0;
  endfunction

  // driver: push stays high across back-to-back items
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) load_pancake('{pancake_value_i, is_last_i});
      if (!push || !full) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          push            <= 1'b1;
          pancake_value_i <= pending_items[0].value;
          is_last_i       <= pending_items[0].last;
          void'(pending_items.pop_front());
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each popped result with the oldest expectation
  always @(posedge clk_i) begin
    sorted_item_t e;
    if (rst_ni) begin
      if (pop && !empty) begin
        result_cnt++;
        if (expected_sorted.size() == 0) begin
          $error("unexpected result item: value %0d", sorted_value_o);
          fail_cnt++;
        end else begin
          e = expected_sorted.pop_front();
          if (sorted_value_o !== e.value) begin
            $error("sorted_value: expected %0d, got %0d", e.value, sorted_value_o);
            fail_cnt++;
          end
          if (move_count_o !== e.moves) begin
            $error("move_count: expected %0d, got %0d", e.moves, move_count_o);
            fail_cnt++;
          end
          if (was_truncated_o !== e.trunc) begin
            $error("was_truncated: expected %0b, got %0b", e.trunc, was_truncated_o);
            fail_cnt++;
          end
          if (last_out_o !== e.last) begin
            $error("last_out: expected %0b, got %0b", e.last, last_out_o);
            fail_cnt++;
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic signed [15:0] rand_pancake();
    case ($urandom_range(9))
      0:       return 16'sh8000;                       // most negative
      1:       return 16'sd0;
      2:       return $urandom_range(1) ? 16'sd32767 : -16'sd32767;
      3:       return 16'($urandom_range(7)) - 16'sd3; // small, ties likely
      default: return 16'($urandom);
    endcase
  endfunction

  // queue one stack of n items (n > DEPTH overflows)
  function automatic void add_stack(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      pending_items.push_back('{rand_pancake(), i == n - 1});
  endfunction

  task automatic drain_out();
    while (pending_items.size() > 0 || push || expected_sorted.size() > 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  initial begin
    int unsigned n;
    stack_cnt = 0;
    move_tally = 0;
    dropped_seen = 1'b0;
    fail_cnt = 0;
    result_cnt = 0;
    stack_runs = 0;
    send_idle_pct = 38;
    recv_idle_pct = 65;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: single pancake, extremes, zero, ties, overflow with last dropped
    pending_items.push_back('{16'sh8000, 1'b1});
    pending_items.push_back('{16'sd0, 1'b1});
    pending_items.push_back('{-16'sd32767, 1'b0});
    pending_items.push_back('{16'sd32767, 1'b0});
    pending_items.push_back('{16'sh8000, 1'b0});
    pending_items.push_back('{16'sd0, 1'b1});
    pending_items.push_back('{16'sd5, 1'b0});
    pending_items.push_back('{-16'sd5, 1'b0});
    pending_items.push_back('{16'sd5, 1'b1});
    for (int i = 0; i < 17; i++)
      pending_items.push_back('{16'(-i), i == 16});

    // random: three phases of about 127 items each, only the first two idling
    for (int ph = 0; ph < 3; ph++) begin
      while (pending_items.size() < 127) begin
        n = ($urandom_range(19) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 16);
        add_stack(n);
      end
      drain_out();
      if (ph == 0) begin
        send_idle_pct = 65;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    end

    $display("Sorted %0d stacks, %0d result items checked.", stack_runs, result_cnt);
    if (fail_cnt == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #4000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/bpsc_pkg.sv
hdl/bpsc_queue.sv
hdl/bpsc_intake.sv
hdl/bpsc_engine.sv
hdl/burnt_pancake_sorter_core.sv
tb/burnt_pancake_sorter_core_tb.sv
